>>> src/selc_pkg.sv
// ----------------------------------------------------------------------------
// selc_pkg
// Shared types and constants of the effective line counter: payload structs,
// configuration bundle, register indexes, lexical modes and character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package selc_pkg;

    // width of line numbers and counts
    localparam int LINE_BITS = 24;
    localparam int CH_BITS   = 16;

    // configuration register file
    localparam int REG_IDX_BITS = 2;
    localparam int APB_ADDR_BITS = REG_IDX_BITS + 2;
    localparam int APB_DATA_BITS = 32;

    localparam logic [REG_IDX_BITS-1:0] REG_TARGET_COUNT = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_START_COUNT  = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_START_LINE   = 2'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_EXT_EOL      = 2'd3;

    // lexical modes
    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_SQUOTE  = 2'd1;
    localparam logic [1:0] MODE_DQUOTE  = 2'd2;
    localparam logic [1:0] MODE_COMMENT = 2'd3;

    // character codes
    localparam logic [CH_BITS-1:0] CH_SQUOTE    = 16'h0027;
    localparam logic [CH_BITS-1:0] CH_DQUOTE    = 16'h0022;
    localparam logic [CH_BITS-1:0] CH_BACKSLASH = 16'h005C;
    localparam logic [CH_BITS-1:0] CH_DASH      = 16'h002D;
    localparam logic [CH_BITS-1:0] CH_SLASH     = 16'h002F;
    localparam logic [CH_BITS-1:0] CH_STAR      = 16'h002A;
    localparam logic [CH_BITS-1:0] CH_SPACE     = 16'h0020;
    localparam logic [CH_BITS-1:0] CH_TAB       = 16'h0009;
    localparam logic [CH_BITS-1:0] CH_CR        = 16'h000D;
    localparam logic [CH_BITS-1:0] CH_LF        = 16'h000A;
    localparam logic [CH_BITS-1:0] CH_NEL       = 16'h0085;
    localparam logic [CH_BITS-1:0] CH_LS        = 16'h2028;
    localparam logic [CH_BITS-1:0] CH_PS        = 16'h2029;

    // input item
    typedef struct packed {
        logic [CH_BITS-1:0] ch;
        logic               line_end;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [LINE_BITS-1:0] line_index;
        logic                 line_effective;
        logic [LINE_BITS-1:0] effective_count;
        logic                 reached;
    } t_out_item;

    // configuration values and load strobes for the scanner
    typedef struct packed {
        logic [LINE_BITS-1:0] target_count;
        logic                 ext_eol_enable;
        logic                 ld_count;
        logic [LINE_BITS-1:0] start_count;
        logic                 ld_line;
        logic [LINE_BITS-1:0] start_line;
    } t_cfg;

endpackage

`default_nettype wire

>>> src/selc_cfg_regs.sv
// ----------------------------------------------------------------------------
// selc_cfg_regs
// APB-style configuration registers: target count, start count, start line
// and the extended line delimiter enable.
// ----------------------------------------------------------------------------
`default_nettype none

module selc_cfg_regs (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [selc_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [selc_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic      [selc_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                      pready,
    output selc_pkg::t_cfg                            o_cfg
);

    logic [selc_pkg::LINE_BITS-1:0]    r_target_count;
    logic [selc_pkg::LINE_BITS-1:0]    r_start_count;
    logic [selc_pkg::LINE_BITS-1:0]    r_start_line;
    logic                              r_ext_eol;
    logic                              wr_en;
    logic [selc_pkg::REG_IDX_BITS-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[selc_pkg::APB_ADDR_BITS-1:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_count <= selc_pkg::LINE_BITS'(1);
            r_start_count  <= '0;
            r_start_line   <= '0;
            r_ext_eol      <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                selc_pkg::REG_TARGET_COUNT: r_target_count <= pwdata[selc_pkg::LINE_BITS-1:0];
                selc_pkg::REG_START_COUNT:  r_start_count  <= pwdata[selc_pkg::LINE_BITS-1:0];
                selc_pkg::REG_START_LINE:   r_start_line   <= pwdata[selc_pkg::LINE_BITS-1:0];
                selc_pkg::REG_EXT_EOL:      r_ext_eol      <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            selc_pkg::REG_TARGET_COUNT: prdata = selc_pkg::APB_DATA_BITS'(r_target_count);
            selc_pkg::REG_START_COUNT:  prdata = selc_pkg::APB_DATA_BITS'(r_start_count);
            selc_pkg::REG_START_LINE:   prdata = selc_pkg::APB_DATA_BITS'(r_start_line);
            selc_pkg::REG_EXT_EOL:      prdata = selc_pkg::APB_DATA_BITS'(r_ext_eol);
            default:                    prdata = '0;
        endcase
    end

    // values and load strobes toward the scanner
    always_comb begin
        o_cfg.target_count   = r_target_count;
        o_cfg.ext_eol_enable = r_ext_eol;
        o_cfg.ld_count       = wr_en && (reg_idx == selc_pkg::REG_START_COUNT);
        o_cfg.start_count    = pwdata[selc_pkg::LINE_BITS-1:0];
        o_cfg.ld_line        = wr_en && (reg_idx == selc_pkg::REG_START_LINE);
        o_cfg.start_line     = pwdata[selc_pkg::LINE_BITS-1:0];
    end

endmodule

`default_nettype wire

>>> src/selc_scanner.sv
// ----------------------------------------------------------------------------
// selc_scanner
// Input register and lexical scan: mode tracking across lines, one-unit
// lookahead, leading blank skip, effective line decision and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module selc_scanner (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire selc_pkg::t_cfg       i_cfg,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire selc_pkg::t_in_item   i_in_data,
    input  wire logic                 i_ready,
    output logic                      o_push,
    output selc_pkg::t_out_item       o_push_data
);

    // per-unit scan state
    typedef struct packed {
        logic [1:0]                   mode;
        logic [selc_pkg::CH_BITS-1:0] prev;
        logic                         rest;
        logic                         skip;
        logic                         flag;
        logic                         cfnz;
    } t_lex;

    function automatic logic is_delim(input logic [selc_pkg::CH_BITS-1:0] c,
                                      input logic ext);
        logic d;
        d = (c == selc_pkg::CH_CR) || (c == selc_pkg::CH_LF);
        if (ext) begin
            d = d || (c == selc_pkg::CH_NEL) || (c == selc_pkg::CH_LS) ||
                (c == selc_pkg::CH_PS);
        end
        return d;
    endfunction

    function automatic t_lex scan_unit(input t_lex s,
                                       input logic [selc_pkg::CH_BITS-1:0] c,
                                       input logic has_next,
                                       input logic [selc_pkg::CH_BITS-1:0] nx,
                                       input logic ext,
                                       input logic line_nz);
        t_lex                         r;
        logic [selc_pkg::CH_BITS-1:0] p;
        logic [selc_pkg::CH_BITS-1:0] close_q;
        r       = s;
        p       = s.prev;
        close_q = (s.mode == selc_pkg::MODE_SQUOTE) ? selc_pkg::CH_SQUOTE
                                                    : selc_pkg::CH_DQUOTE;
        if (s.skip) begin
            r.skip = 1'b0;
        end else if (!s.rest) begin
            r.prev = c;
            case (s.mode) inside
                selc_pkg::MODE_SQUOTE, selc_pkg::MODE_DQUOTE: begin
                    r.flag = 1'b1;
                    if (c == close_q && p != selc_pkg::CH_BACKSLASH) begin
                        r.mode = selc_pkg::MODE_NORMAL;
                    end
                end
                selc_pkg::MODE_COMMENT: begin
                    if (has_next && c == selc_pkg::CH_STAR && nx == selc_pkg::CH_SLASH) begin
                        if (s.cfnz) begin
                            r.flag = 1'b1;
                        end
                        r.skip = 1'b1;
                        r.mode = selc_pkg::MODE_NORMAL;
                    end
                end
                default: begin
                    if (c == selc_pkg::CH_TAB || c == selc_pkg::CH_SPACE || is_delim(c, ext)) begin
                        // blank or delimiter, nothing to do
                    end else if (has_next && c == selc_pkg::CH_DASH &&
                                 nx == selc_pkg::CH_DASH) begin
                        r.flag = 1'b1;
                        r.rest = 1'b1;
                    end else if (has_next && c == selc_pkg::CH_SLASH &&
                                 nx == selc_pkg::CH_STAR) begin
                        r.skip = 1'b1;
                        r.mode = selc_pkg::MODE_COMMENT;
                        r.cfnz = line_nz;
                    end else if (c == selc_pkg::CH_SQUOTE) begin
                        r.mode = selc_pkg::MODE_SQUOTE;
                    end else if (c == selc_pkg::CH_DQUOTE) begin
                        r.mode = selc_pkg::MODE_DQUOTE;
                    end else begin
                        r.flag = 1'b1;
                    end
                end
            endcase
        end
        return r;
    endfunction

    localparam logic [selc_pkg::LINE_BITS-1:0] CNT_MAX = '1;

    // input register
    logic                           r_in_valid;
    selc_pkg::t_in_item             r_in;
    logic                           accept;
    logic                           proc;

    // scan state
    t_lex                           r_lex;
    t_lex                           n_lex;
    logic [selc_pkg::CH_BITS-1:0]   r_held;
    logic [selc_pkg::CH_BITS-1:0]   n_held;
    logic                           r_held_valid;
    logic                           n_held_valid;
    logic                           r_lead;
    logic                           n_lead;
    logic                           r_fnb;
    logic                           n_fnb;
    logic [selc_pkg::LINE_BITS-1:0] r_line;
    logic [selc_pkg::LINE_BITS-1:0] n_line;
    logic [selc_pkg::LINE_BITS-1:0] r_count;
    logic [selc_pkg::LINE_BITS-1:0] n_count;
    logic                           r_finished;
    logic                           n_finished;

    logic                           n_push;
    selc_pkg::t_out_item            n_push_data;

    assign o_in_stall = r_in_valid && !i_ready;
    assign accept     = i_in_valid && !o_in_stall;
    assign proc       = r_in_valid && i_ready;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    // scan of one item: held unit with lookahead, then the current unit at a line end (else it is held)
    always_comb begin
        logic                           drop;
        logic                           lf;
        logic [selc_pkg::LINE_BITS-1:0] tgt;
        logic [selc_pkg::LINE_BITS-1:0] cnt;
        logic                           hit;
        t_lex                           s;
        drop = 1'b0;
        lf   = 1'b0;
        tgt  = '0;
        cnt  = r_count;
        hit  = 1'b0;
        s    = r_lex;

        n_lex        = r_lex;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_lead       = r_lead;
        n_fnb        = r_fnb;
        n_line       = r_line;
        n_count      = r_count;
        n_finished   = r_finished;
        n_push       = 1'b0;
        n_push_data  = '0;

        if (proc && !r_finished) begin
            if (r_held_valid) begin
                s = scan_unit(s, r_held, 1'b1, r_in.ch, i_cfg.ext_eol_enable,
                              r_line != '0);
                n_held_valid = 1'b0;
            end
            drop = r_lead && (r_in.ch == selc_pkg::CH_SPACE || r_in.ch == selc_pkg::CH_TAB);
            if (!drop) begin
                if (r_lead) begin
                    n_lead = 1'b0;
                    n_fnb  = is_delim(r_in.ch, i_cfg.ext_eol_enable);
                end
                if (r_in.line_end) begin
                    s = scan_unit(s, r_in.ch, 1'b0, '0, i_cfg.ext_eol_enable,
                                  r_line != '0);
                end else begin
                    n_held       = r_in.ch;
                    n_held_valid = 1'b1;
                end
            end
            n_lex = s;

            // line end: decision, counters and per-line reset
            if (r_in.line_end) begin
                lf = s.flag;
                if (s.mode == selc_pkg::MODE_COMMENT) begin
                    if (s.cfnz) begin
                        lf = 1'b1;
                    end
                    if (n_fnb) begin
                        lf = 1'b0;
                    end
                end
                tgt = (i_cfg.target_count == '0) ? selc_pkg::LINE_BITS'(1)
                                                 : i_cfg.target_count;
                if (lf) begin
                    if (r_count != CNT_MAX) begin
                        cnt = r_count + selc_pkg::LINE_BITS'(1);
                    end
                    hit = (cnt >= tgt);
                end
                n_push                      = 1'b1;
                n_push_data.line_index      = r_line;
                n_push_data.line_effective  = lf;
                n_push_data.effective_count = cnt;
                n_push_data.reached         = hit;

                n_count    = cnt;
                n_finished = hit;
                if (r_line != CNT_MAX) begin
                    n_line = r_line + selc_pkg::LINE_BITS'(1);
                end
                n_held_valid = 1'b0;
                n_held       = '0;
                n_lex.prev   = '0;
                n_lex.rest   = 1'b0;
                n_lex.skip   = 1'b0;
                n_lex.flag   = 1'b0;
                n_lead       = 1'b1;
                n_fnb        = 1'b0;
            end
        end

        // configuration loads
        if (i_cfg.ld_count) begin
            n_count = i_cfg.start_count;
        end
        if (i_cfg.ld_line) begin
            n_line = i_cfg.start_line;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lex        <= '{mode: selc_pkg::MODE_NORMAL, prev: '0, rest: 1'b0,
                              skip: 1'b0, flag: 1'b0, cfnz: 1'b0};
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_lead       <= 1'b1;
            r_fnb        <= 1'b0;
            r_line       <= '0;
            r_count      <= '0;
            r_finished   <= 1'b0;
        end else begin
            r_lex        <= n_lex;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_lead       <= n_lead;
            r_fnb        <= n_fnb;
            r_line       <= n_line;
            r_count      <= n_count;
            r_finished   <= n_finished;
        end
    end

    assign o_push      = n_push;
    assign o_push_data = n_push_data;

endmodule

`default_nettype wire

>>> src/selc_out_buf.sv
// ----------------------------------------------------------------------------
// selc_out_buf
// Result register with a skid stage, so the scanner keeps going while a
// finished result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module selc_out_buf (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire selc_pkg::t_out_item  i_push_data,
    output logic                      o_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output selc_pkg::t_out_item       o_out_data
);

    logic                r_out_valid;
    selc_pkg::t_out_item r_out;
    logic                r_skid_valid;
    selc_pkg::t_out_item r_skid;
    logic                pop;

    assign pop     = r_out_valid && !i_out_stall;
    assign o_ready = !r_skid_valid;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skid <= i_push_data;
            end else begin
                r_out <= i_push_data;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> src/sql_effective_line_counter_top.sv
// Path: a line end item is captured in the input register, scanned combinationally
// and written to the result register, or its skid stage, while the skid is free.
// Throughput: one item per cycle from the combinational scan between the input
// register and the result register; the input stalls only while the result
// register and its skid stage are both full.
// Reset: synchronous active low; clears mode, counters and valid flags at once.
// ----------------------------------------------------------------------------
// sql_effective_line_counter_top
// Effective line counter for SQL-like text, one code unit per item, with an
// APB-style configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module sql_effective_line_counter_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [selc_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [selc_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic      [selc_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                    pready,
    // character input
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire selc_pkg::t_in_item                 i_in_data,
    // line results
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output selc_pkg::t_out_item                     o_out_data
);

    selc_pkg::t_cfg      cfg;
    logic                ready;
    logic                push;
    selc_pkg::t_out_item push_data;

    // configuration registers
    selc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // lexical scan and counters
    selc_scanner u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_ready     (ready),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // result register and skid
    selc_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_ready     (ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> sim/selc_line_checker.sv
// ----------------------------------------------------------------------------
// selc_line_checker
// Watches the configuration port and both item channels of the effective line
// counter. It keeps its own model of the lexer and the line counters, predicts
// the report of every finished line and compares each result field by field.
// ----------------------------------------------------------------------------
module selc_line_checker
    import selc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // configuration port
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    input  wire logic                     pready,
    // character channel
    input  wire logic                     i_in_valid,
    input  wire logic                     i_in_stall,
    input  t_in_item                      i_in_data,
    // line result channel
    input  wire logic                     i_out_valid,
    input  wire logic                     i_out_stall,
    input  t_out_item                     i_out_data,
    // status towards the testbench top
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [LINE_BITS-1:0] CNT_MAX = '1;

    // mirrored configuration
    logic [LINE_BITS-1:0] target;
    logic [LINE_BITS-1:0] first_count;
    logic [LINE_BITS-1:0] first_line;
    logic                 ext_eol;

    // lexer and counter state
    logic [1:0]           mode;
    logic [CH_BITS-1:0]   held_ch;
    logic                 held_v;
    logic [CH_BITS-1:0]   prev_ch;
    logic                 lead_blank;
    logic                 first_is_eol;
    logic                 rest_skip;
    logic                 skip_one;
    logic                 line_eff;
    logic                 cmt_nonzero;
    logic [LINE_BITS-1:0] cur_line;
    logic [LINE_BITS-1:0] eff_count;
    logic                 done;

    // reports of finished lines still to come out of the block
    t_out_item            pending_lines[$];

    initial o_fail_count = 0;
    initial o_pending = 0;

    function automatic logic is_eol(input logic [CH_BITS-1:0] c);
        if (c == CH_CR || c == CH_LF) return 1'b1;
        return ext_eol && (c == CH_NEL || c == CH_LS || c == CH_PS);
    endfunction

    task automatic clear_line_state();
        held_v       = 1'b0;
        held_ch      = '0;
        prev_ch      = '0;
        lead_blank   = 1'b1;
        first_is_eol = 1'b0;
        rest_skip    = 1'b0;
        skip_one     = 1'b0;
        line_eff     = 1'b0;
    endtask

    task automatic reset_model();
        target      = 1;
        first_count = '0;
        first_line  = '0;
        ext_eol     = 1'b0;
        mode        = MODE_NORMAL;
        cmt_nonzero = 1'b0;
        cur_line    = '0;
        eff_count   = '0;
        done        = 1'b0;
        clear_line_state();
    endtask

    // one code unit through the lexer, with its lookahead when there is one
    task automatic scan_char(input logic [CH_BITS-1:0] c, input logic has_nx,
                             input logic [CH_BITS-1:0] nx);
        logic [CH_BITS-1:0] p;
        if (skip_one) begin
            skip_one = 1'b0;
        end else if (!rest_skip) begin
            p = prev_ch;
            prev_ch = c;
            case (mode)
                MODE_SQUOTE, MODE_DQUOTE: begin
                    line_eff = 1'b1;
                    if (c == ((mode == MODE_SQUOTE) ? CH_SQUOTE : CH_DQUOTE) &&
                        p != CH_BACKSLASH)
                        mode = MODE_NORMAL;
                end
                MODE_COMMENT: begin
                    if (has_nx && c == CH_STAR && nx == CH_SLASH) begin
                        if (cmt_nonzero) line_eff = 1'b1;
                        skip_one = 1'b1;
                        mode = MODE_NORMAL;
                    end
                end
                default: begin
                    if (!(c == CH_TAB || c == CH_SPACE || is_eol(c))) begin
                        if (has_nx && c == CH_DASH && nx == CH_DASH) begin
                            line_eff  = 1'b1;
                            rest_skip = 1'b1;
                        end else if (has_nx && c == CH_SLASH && nx == CH_STAR) begin
                            skip_one    = 1'b1;
                            mode        = MODE_COMMENT;
                            cmt_nonzero = (cur_line != '0);
                        end else if (c == CH_SQUOTE) begin
                            mode = MODE_SQUOTE;
                        end else if (c == CH_DQUOTE) begin
                            mode = MODE_DQUOTE;
                        end else begin
                            line_eff = 1'b1;
                        end
                    end
                end
            endcase
        end
    endtask

    // accepted character item; queues a line report at a line end
    task automatic predict_char(input t_in_item it);
        logic                 hit;
        logic [LINE_BITS-1:0] goal;
        t_out_item            rep;
        if (!done) begin
            if (held_v) begin
                scan_char(held_ch, 1'b1, it.ch);
                held_v = 1'b0;
            end
            if (!(lead_blank && (it.ch == CH_SPACE || it.ch == CH_TAB))) begin
                if (lead_blank) begin
                    lead_blank   = 1'b0;
                    first_is_eol = is_eol(it.ch);
                end
                if (it.line_end) begin
                    scan_char(it.ch, 1'b0, '0);
                end else begin
                    held_ch = it.ch;
                    held_v  = 1'b1;
                end
            end
            if (it.line_end) begin
                // a line ending inside a comment
                if (mode == MODE_COMMENT) begin
                    if (cmt_nonzero) line_eff = 1'b1;
                    if (first_is_eol) line_eff = 1'b0;
                end
                hit = 1'b0;
                if (line_eff) begin
                    if (eff_count != CNT_MAX) eff_count++;
                    goal = (target == '0) ? 1 : target;
                    hit  = (eff_count >= goal);
                end
                rep.line_index      = cur_line;
                rep.line_effective  = line_eff;
                rep.effective_count = eff_count;
                rep.reached         = hit;
                pending_lines.push_back(rep);
                if (hit) done = 1'b1;
                if (cur_line != CNT_MAX) cur_line++;
                clear_line_state();
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("line report mismatch on %s: got %0h, expected %0h", what, got, want);
        o_fail_count++;
    endtask

    // sample all channels at the clock edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            reset_model();
            pending_lines.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_BITS-1:2])
                    REG_TARGET_COUNT: target = pwdata[LINE_BITS-1:0];
                    REG_START_COUNT: begin
                        first_count = pwdata[LINE_BITS-1:0];
                        eff_count   = first_count;
                    end
                    REG_START_LINE: begin
                        first_line = pwdata[LINE_BITS-1:0];
                        cur_line   = first_line;
                    end
                    REG_EXT_EOL: ext_eol = pwdata[0];
                    default: ;
                endcase
            end
            // results first: an item taken at this edge cannot leave at it
            if (i_out_valid && !i_out_stall) begin
                if (pending_lines.size() == 0) begin
                    report_mismatch("unexpected result, line_index",
                                    i_out_data.line_index, '0);
                end else begin
                    want = pending_lines.pop_front();
                    if (i_out_data.line_index !== want.line_index)
                        report_mismatch("line_index", i_out_data.line_index,
                                        want.line_index);
                    if (i_out_data.line_effective !== want.line_effective)
                        report_mismatch("line_effective", i_out_data.line_effective,
                                        want.line_effective);
                    if (i_out_data.effective_count !== want.effective_count)
                        report_mismatch("effective_count", i_out_data.effective_count,
                                        want.effective_count);
                    if (i_out_data.reached !== want.reached)
                        report_mismatch("reached", i_out_data.reached, want.reached);
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_char(i_in_data);
        end
        o_pending = pending_lines.size();
    end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the effective line counter: drives SQL-like lines through the
// character channel with bursty timing, stalls the result channel on its own
// pattern, reprograms the registers between phases and gives the verdict from
// the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import selc_pkg::*;

    localparam logic [LINE_BITS-1:0] CNT_MAX = '1;
    localparam int IDLE_LIMIT     = 4000;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int RAND_PHASES    = 4;
    localparam int PHASE_ITEMS    = 310;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    t_in_item                 in_data = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    t_out_item                out_data;
    int                       fail_count;
    int                       pending;

    logic                     in_fire;
    logic                     out_fire;
    logic                     cfg_fire;
    int                       n_in = 0;
    int                       burst_left = 0;
    bit                       held_off = 1'b0;
    logic [CH_BITS-1:0]       line_buf[$];

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;
    assign cfg_fire = psel && penable && pwrite && pready;

    sql_effective_line_counter_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    selc_line_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        if (in_fire) n_in++;
    end

    // watchdog on cycles with no transfer anywhere
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if (in_fire || out_fire || cfg_fire) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    // result side stall pattern, with one long hold-off to back the block up
    initial begin
        int seg_len;
        int seg_kind;
        logic v;
        forever begin
            if (!held_off && n_in >= 300) begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_LEN) @(posedge clk);
                held_off = 1'b1;
            end else begin
                seg_len  = $urandom_range(5, 60);
                seg_kind = $urandom_range(0, 3);
                for (int k = 0; k < seg_len; k++) begin
                    case (seg_kind)
                        0: v = 1'b0;
                        1: v = $urandom_range(0, 1);
                        2: v = ($urandom_range(0, 3) != 0);
                        default: v = ((k % 3) == 0);
                    endcase
                    out_stall <= v;
                    @(posedge clk);
                end
            end
        end
    end

    // register write: setup cycle, then access cycle until pready
    task automatic reg_write(input logic [REG_IDX_BITS-1:0] idx,
                             input logic [APB_DATA_BITS-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // 24-bit register with random junk in the unused upper bits
    task automatic write_count_reg(input logic [REG_IDX_BITS-1:0] idx,
                                   input logic [LINE_BITS-1:0] val);
        reg_write(idx, {8'($urandom), val});
    endtask

    task automatic write_all(input logic [LINE_BITS-1:0] tgt,
                             input logic [LINE_BITS-1:0] cnt,
                             input logic [LINE_BITS-1:0] line, input logic ext);
        write_count_reg(REG_TARGET_COUNT, tgt);
        write_count_reg(REG_START_COUNT, cnt);
        write_count_reg(REG_START_LINE, line);
        reg_write(REG_EXT_EOL, {31'($urandom), ext});
    endtask

    // one character item, sent in bursts with random gaps
    task automatic send_unit(input logic [CH_BITS-1:0] c, input logic le);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_data  <= '{ch: c, line_end: le};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back({8'h00, s[i]});
    endtask

    // sends the buffered line, flagging its last unit
    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_unit(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic send_str_line(input string s);
        put_str(s);
        send_line();
    endtask

    // lets every report drain, plus the pipeline depth for lines in flight
    task automatic wait_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    // random SQL-like line: mostly well formed tokens, some noise
    task automatic build_line();
        int n_tok;
        int n;
        if ($urandom_range(0, 1)) begin
            n = $urandom_range(1, 3);
            repeat (n) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        end
        n_tok = $urandom_range(0, 5);
        repeat (n_tok) begin
            case ($urandom_range(0, 19))
                5: begin
                    n = $urandom_range(1, 3);
                    repeat (n) line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                end
                6: begin
                    line_buf.push_back(CH_SQUOTE);
                    put_str("ab");
                    line_buf.push_back(CH_SQUOTE);
                end
                7: begin
                    line_buf.push_back(CH_DQUOTE);
                    put_str("id");
                    line_buf.push_back(CH_DQUOTE);
                end
                8: put_str("'x\\''");
                9: put_str("-- c");
                10: put_str("/*");
                11: put_str("*/");
                12: begin
                    case ($urandom_range(0, 5))
                        0: line_buf.push_back(CH_SQUOTE);
                        1: line_buf.push_back(CH_DQUOTE);
                        2: line_buf.push_back(CH_BACKSLASH);
                        3: line_buf.push_back(CH_DASH);
                        4: line_buf.push_back(CH_SLASH);
                        default: line_buf.push_back(CH_STAR);
                    endcase
                end
                13: line_buf.push_back($urandom_range(0, 65535));
                14: begin
                    case ($urandom_range(0, 4))
                        0: line_buf.push_back(CH_CR);
                        1: line_buf.push_back(CH_LF);
                        2: line_buf.push_back(CH_NEL);
                        3: line_buf.push_back(CH_LS);
                        default: line_buf.push_back(CH_PS);
                    endcase
                end
                15: put_str($urandom_range(0, 1) ? "=;" : "(,)");
                default: begin
                    n = $urandom_range(1, 4);
                    repeat (n) line_buf.push_back({8'h00, 8'($urandom_range(8'h61, 8'h7a))});
                end
            endcase
        end
        // line ending
        case ($urandom_range(0, 7))
            0, 1, 2, 3: line_buf.push_back(CH_LF);
            4: begin
                line_buf.push_back(CH_CR);
                line_buf.push_back(CH_LF);
            end
            5: line_buf.push_back(CH_NEL);
            6: line_buf.push_back($urandom_range(0, 1) ? CH_LS : CH_PS);
            default: if (line_buf.size() == 0) line_buf.push_back(CH_SPACE);
        endcase
    endtask

    // stimulus and verdict
    initial begin
        int n_phase;
        logic [LINE_BITS-1:0] cnt0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // far target, line numbering from zero, standard delimiters only
        write_all(CNT_MAX, '0, '0, 1'b0);

        // comment opened on line zero, closer does not count
        send_str_line("/*\n");
        send_str_line("\t*/\n");
        // comment opened on a nonzero line, delimiter-only line inside it
        send_str_line("/*\n");
        send_str_line("\n");
        send_str_line("*/\n");
        // escaped quote inside a string, then double dash hiding a quote
        send_str_line("'\\''\n");
        send_str_line("--'\n");
        // extreme code units; NEL is ordinary text here
        line_buf.push_back(16'hFFFF);
        line_buf.push_back(CH_NEL);
        line_buf.push_back(16'h0000);
        send_line();
        // all-blank line without delimiter
        send_str_line(" ");
        wait_drained();

        // extended delimiters and line index saturation
        write_count_reg(REG_START_LINE, CNT_MAX - 1);
        reg_write(REG_EXT_EOL, {31'($urandom), 1'b1});
        line_buf.push_back(CH_LS);
        send_line();
        line_buf.push_back(CH_NEL);
        send_line();
        line_buf.push_back(CH_PS);
        send_line();
        wait_drained();

        // random phases with unreachable targets
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            cnt0 = $urandom_range(0, 1 << 20);
            write_all((ph == 1) ? CNT_MAX : LINE_BITS'($urandom_range(1 << 23, CNT_MAX)),
                      (ph == 0) ? '0 : cnt0,
                      (ph == 0 || $urandom_range(0, 1)) ? '0
                                                       : LINE_BITS'($urandom_range(1, 1 << 20)),
                      ph[0]);
            n_phase = 0;
            while (n_phase < PHASE_ITEMS) begin
                build_line();
                n_phase += line_buf.size();
                send_line();
            end
            wait_drained();
        end

        // zero target acts as one, count saturates, then input is ignored
        write_count_reg(REG_TARGET_COUNT, '0);
        write_count_reg(REG_START_COUNT, CNT_MAX);
        send_str_line(" ");
        send_str_line("*/\n");
        send_str_line("x\n");
        send_str_line("y\n");
        wait_drained();

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
